[sv/rigid_pose_point_transform_top_defines.svh]
// assertion macros for the rigid pose point transform rtl, used by rpt_pipe
`ifndef RIGID_POSE_POINT_TRANSFORM_TOP_DEFINES_SVH
`define RIGID_POSE_POINT_TRANSFORM_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define RPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rpt_pkg.sv]
// shared types and constants of the rigid pose point transform
`default_nettype none

package rpt_pkg;

   // fixed field widths
   localparam int COORD_BITS     = 24;
   localparam int ROT_BITS       = 16;
   localparam int ROT_W_BITS     = 32;
   localparam int QUAT_FRAC_BITS = 14;

   // register port
   localparam int DATA_BITS    = 32;
   localparam int ADDR_BITS    = 5;
   localparam int REG_IDX_BITS = 3;

   // vector lanes and the other two axes used by each cross product lane
   localparam int AXES = 3;

   // register map, one word per register
   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_SHIFT_X = 3'd0,
      REG_SHIFT_Y = 3'd1,
      REG_SHIFT_Z = 3'd2,
      REG_ROT_W   = 3'd3,
      REG_ROT_X   = 3'd4,
      REG_ROT_Y   = 3'd5,
      REG_ROT_Z   = 3'd6
   } rpt_reg_type;

   // input point beat
   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
   } rpt_point_type;

   // result beat
   typedef struct packed {
      logic signed [COORD_BITS-1:0] moved_x;
      logic signed [COORD_BITS-1:0] moved_y;
      logic signed [COORD_BITS-1:0] moved_z;
      logic                         clipped;
   } rpt_moved_type;

   // pose seen by the datapath; rot_w is sign extended to full width
   typedef struct packed {
      logic signed [COORD_BITS-1:0] shift_x;
      logic signed [COORD_BITS-1:0] shift_y;
      logic signed [COORD_BITS-1:0] shift_z;
      logic signed [ROT_W_BITS-1:0] rot_w;
      logic signed [ROT_BITS-1:0]   rot_x;
      logic signed [ROT_BITS-1:0]   rot_y;
      logic signed [ROT_BITS-1:0]   rot_z;
   } rpt_cfg_type;

endpackage

`default_nettype wire

[sv/rigid_pose_point_transform_top.sv]
// top level of the rigid pose point transform
`default_nettype none

// Rotates each streamed 3-D point by the unit quaternion in rot_w/x/y/z (signed,
// QUAT_FRAC_BITS fraction bits) and adds shift_x/y/z; each coordinate saturates
// to the signed 24-bit range and clipped flags any saturation. One point enters
// per cycle unless the result side stalls; the pipeline stages are u x v
// products, rounding of t = 2(u x v), w t and u x t products, accumulation, then
// round, translate and saturate into the output register. Back-pressure on the
// result side stalls the stages in order, so bubbles are squeezed out before
// req_ready drops. Registers sit at byte addresses 4*i (shift_x, shift_y,
// shift_z, rot_w, rot_x, rot_y, rot_z); write them only while no point is in
// flight. The quaternion is used as written and is not renormalised.

module rigid_pose_point_transform_top #(
   parameter int QUAT_FRAC_BITS = rpt_pkg::QUAT_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire rpt_pkg::rpt_point_type        req_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output rpt_pkg::rpt_moved_type             rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rpt_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [rpt_pkg::DATA_BITS-1:0] pwdata,
   output      logic [rpt_pkg::DATA_BITS-1:0] prdata,
   output      logic                          pready
);

   rpt_pkg::rpt_cfg_type cfg;

   // pose registers
   rpt_csr #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // point pipeline
   rpt_pipe #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[sv/rpt_csr.sv]
// pose register file behind the apb-style port
`default_nettype none

module rpt_csr #(
   parameter int QUAT_FRAC_BITS = rpt_pkg::QUAT_FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rpt_pkg::ADDR_BITS-1:0]     paddr,
   input  wire logic [rpt_pkg::DATA_BITS-1:0]     pwdata,
   output      logic [rpt_pkg::DATA_BITS-1:0]     prdata,
   output      logic                              pready,
   output      rpt_pkg::rpt_cfg_type              cfg
);

   localparam int CB = rpt_pkg::COORD_BITS;
   localparam int RB = rpt_pkg::ROT_BITS;
   localparam int DB = rpt_pkg::DATA_BITS;
   // rot_w must also hold its reset value of one
   localparam int RW = (QUAT_FRAC_BITS + 2 > RB) ? QUAT_FRAC_BITS + 2 : RB;
   localparam logic [RW-1:0] ROT_W_ONE = RW'(1) << QUAT_FRAC_BITS;

   logic signed [CB-1:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic signed [CB-1:0] shift_x_in, shift_y_in, shift_z_in;
   logic signed [RW-1:0] rot_w_ff, rot_w_in;
   logic signed [RB-1:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [RB-1:0] rot_x_in, rot_y_in, rot_z_in;

   logic                 wr_en;
   rpt_pkg::rpt_reg_type reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = rpt_pkg::rpt_reg_type'(paddr[rpt_pkg::ADDR_BITS-1:2]);

   // write decode
   always_comb begin
      shift_x_in = shift_x_ff;
      shift_y_in = shift_y_ff;
      shift_z_in = shift_z_ff;
      rot_w_in   = rot_w_ff;
      rot_x_in   = rot_x_ff;
      rot_y_in   = rot_y_ff;
      rot_z_in   = rot_z_ff;
      if (wr_en) begin
         unique case (reg_idx)
            rpt_pkg::REG_SHIFT_X: shift_x_in = pwdata[CB-1:0];
            rpt_pkg::REG_SHIFT_Y: shift_y_in = pwdata[CB-1:0];
            rpt_pkg::REG_SHIFT_Z: shift_z_in = pwdata[CB-1:0];
            rpt_pkg::REG_ROT_W:   rot_w_in   = RW'($signed(pwdata[RB-1:0]));
            rpt_pkg::REG_ROT_X:   rot_x_in   = pwdata[RB-1:0];
            rpt_pkg::REG_ROT_Y:   rot_y_in   = pwdata[RB-1:0];
            rpt_pkg::REG_ROT_Z:   rot_z_in   = pwdata[RB-1:0];
            default: ;
         endcase
      end
   end

   // pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= '0;
         rot_w_ff   <= ROT_W_ONE;
         rot_x_ff   <= '0;
         rot_y_ff   <= '0;
         rot_z_ff   <= '0;
      end else begin
         shift_x_ff <= shift_x_in;
         shift_y_ff <= shift_y_in;
         shift_z_ff <= shift_z_in;
         rot_w_ff   <= rot_w_in;
         rot_x_ff   <= rot_x_in;
         rot_y_ff   <= rot_y_in;
         rot_z_ff   <= rot_z_in;
      end
   end

   // read mux, values sign extended to the bus
   always_comb begin
      unique case (reg_idx)
         rpt_pkg::REG_SHIFT_X: prdata = DB'(shift_x_ff);
         rpt_pkg::REG_SHIFT_Y: prdata = DB'(shift_y_ff);
         rpt_pkg::REG_SHIFT_Z: prdata = DB'(shift_z_ff);
         rpt_pkg::REG_ROT_W:   prdata = DB'(rot_w_ff);
         rpt_pkg::REG_ROT_X:   prdata = DB'(rot_x_ff);
         rpt_pkg::REG_ROT_Y:   prdata = DB'(rot_y_ff);
         rpt_pkg::REG_ROT_Z:   prdata = DB'(rot_z_ff);
         default:              prdata = '0;
      endcase
   end

   // pose out to the datapath
   always_comb begin
      cfg.shift_x = shift_x_ff;
      cfg.shift_y = shift_y_ff;
      cfg.shift_z = shift_z_ff;
      cfg.rot_w   = rpt_pkg::ROT_W_BITS'(rot_w_ff);
      cfg.rot_x   = rot_x_ff;
      cfg.rot_y   = rot_y_ff;
      cfg.rot_z   = rot_z_ff;
   end

endmodule

`default_nettype wire

[sv/rpt_pipe.sv]
// five stage rotate, translate and saturate pipeline
`default_nettype none

`include "rigid_pose_point_transform_top_defines.svh"

module rpt_pipe #(
   parameter int QUAT_FRAC_BITS = rpt_pkg::QUAT_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rpt_pkg::rpt_cfg_type  cfg,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire rpt_pkg::rpt_point_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output rpt_pkg::rpt_moved_type     rsp_data
);

   localparam int F   = QUAT_FRAC_BITS;
   localparam int N   = rpt_pkg::AXES;
   localparam int CB  = rpt_pkg::COORD_BITS;
   localparam int RB  = rpt_pkg::ROT_BITS;
   localparam int RW  = (F + 2 > RB) ? F + 2 : RB;
   // u x v products and their difference
   localparam int PW  = RB + CB;
   localparam int CW  = PW + 1;
   // t = 2 (u x v), rounded to whole coordinate units
   localparam int TW  = CW - F + 1;
   localparam int WPW = RW + TW;
   localparam int XPW = RB + TW;
   // accumulator holds v * 2^F + w t + u x t
   localparam int AW1 = CB + F;
   localparam int AW2 = (WPW > XPW + 1) ? WPW : XPW + 1;
   localparam int AW  = ((AW1 > AW2) ? AW1 : AW2) + 2;
   localparam int RSW = AW - F;
   localparam int SW  = RSW + 1;

   localparam logic signed [CW-1:0] BIAS_T = CW'(1) << (F - 2);
   localparam logic signed [AW-1:0] BIAS_A = AW'(1) << (F - 1);
   localparam logic signed [CB-1:0] SAT_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] SAT_MIN = {1'b1, {(CB-1){1'b0}}};

   // pose and point as lanes
   logic signed [RB-1:0] rot_u [N];
   logic signed [RW-1:0] rot_w;
   logic signed [CB-1:0] shift [N];
   logic signed [CB-1:0] v0 [N];

   assign rot_u[0] = cfg.rot_x;
   assign rot_u[1] = cfg.rot_y;
   assign rot_u[2] = cfg.rot_z;
   assign rot_w    = cfg.rot_w[RW-1:0];
   assign shift[0] = cfg.shift_x;
   assign shift[1] = cfg.shift_y;
   assign shift[2] = cfg.shift_z;
   assign v0[0]    = req_data.point_x;
   assign v0[1]    = req_data.point_y;
   assign v0[2]    = req_data.point_z;

   // stage registers
   logic                 vld1_ff, vld2_ff, vld3_ff, vld4_ff, rsp_vld_ff;
   logic                 rdy1, rdy2, rdy3, rdy4, rdy5;

   logic signed [CB-1:0]  v1_ff  [N], v2_ff [N], v3_ff [N];
   logic signed [PW-1:0]  pa1_ff [N], pb1_ff [N];
   logic signed [PW-1:0]  pa1_in [N], pb1_in [N];
   logic signed [TW-1:0]  t2_ff  [N], t2_in [N];
   logic signed [WPW-1:0] wt3_ff [N], wt3_in [N];
   logic signed [XPW-1:0] xa3_ff [N], xb3_ff [N];
   logic signed [XPW-1:0] xa3_in [N], xb3_in [N];
   logic signed [AW-1:0]  acc4_ff [N], acc4_in [N];
   logic signed [CB-1:0]  mv_in [N];
   logic [N-1:0]          over;
   rpt_pkg::rpt_moved_type rsp_ff;

   // per-lane arithmetic; lane i crosses axes j and k
   for (genvar g = 0; g < N; g++) begin : g_lane
      localparam int J = (g + 1) % N;
      localparam int K = (g + 2) % N;

      logic signed [CW-1:0] c_sum;
      logic signed [AW-1:0] a_rnd;
      logic signed [SW-1:0] r_sum;

      // stage 1: u x v partial products
      assign pa1_in[g] = PW'(rot_u[J]) * PW'(v0[K]);
      assign pb1_in[g] = PW'(rot_u[K]) * PW'(v0[J]);

      // stage 2: t = (u x v) / 2^(F-1), rounded half up
      assign c_sum    = CW'(pa1_ff[g]) - CW'(pb1_ff[g]) + BIAS_T;
      assign t2_in[g] = c_sum[CW-1:F-1];

      // stage 3: w t and u x t partial products
      assign wt3_in[g] = WPW'(rot_w) * WPW'(t2_ff[g]);
      assign xa3_in[g] = XPW'(rot_u[J]) * XPW'(t2_ff[K]);
      assign xb3_in[g] = XPW'(rot_u[K]) * XPW'(t2_ff[J]);

      // stage 4: accumulate at scale 2^F
      assign acc4_in[g] = (AW'(v3_ff[g]) <<< F) + AW'(wt3_ff[g])
                        + AW'(xa3_ff[g]) - AW'(xb3_ff[g]);

      // stage 5: round, translate and saturate
      assign a_rnd   = acc4_ff[g] + BIAS_A;
      assign r_sum   = SW'($signed(a_rnd[AW-1:F])) + SW'(shift[g]);
      assign over[g] = (|r_sum[SW-1:CB-1]) && !(&r_sum[SW-1:CB-1]);
      assign mv_in[g] = over[g] ? (r_sum[SW-1] ? SAT_MIN : SAT_MAX) : r_sum[CB-1:0];
   end

   // backpressure: a stage loads when empty or when its successor loads
   assign rdy5      = !rsp_vld_ff || rsp_ready;
   assign rdy4      = !vld4_ff || rdy5;
   assign rdy3      = !vld3_ff || rdy4;
   assign rdy2      = !vld2_ff || rdy3;
   assign rdy1      = !vld1_ff || rdy2;
   assign req_ready = rdy1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         vld4_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff    <= req_valid;
         if (rdy2) vld2_ff    <= vld1_ff;
         if (rdy3) vld3_ff    <= vld2_ff;
         if (rdy4) vld4_ff    <= vld3_ff;
         if (rdy5) rsp_vld_ff <= vld4_ff;
      end
   end

   // datapath registers, held while their stage stalls
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (rdy1) begin
            v1_ff[i]  <= v0[i];
            pa1_ff[i] <= pa1_in[i];
            pb1_ff[i] <= pb1_in[i];
         end
         if (rdy2) begin
            v2_ff[i] <= v1_ff[i];
            t2_ff[i] <= t2_in[i];
         end
         if (rdy3) begin
            v3_ff[i]  <= v2_ff[i];
            wt3_ff[i] <= wt3_in[i];
            xa3_ff[i] <= xa3_in[i];
            xb3_ff[i] <= xb3_in[i];
         end
         if (rdy4) begin
            acc4_ff[i] <= acc4_in[i];
         end
      end
      if (rdy5) begin
         rsp_ff.moved_x <= mv_in[0];
         rsp_ff.moved_y <= mv_in[1];
         rsp_ff.moved_z <= mv_in[2];
         rsp_ff.clipped <= |over;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // a clipped beat carries at least one rail value
   logic sat_x, sat_y, sat_z;
   assign sat_x = (rsp_ff.moved_x == SAT_MAX) || (rsp_ff.moved_x == SAT_MIN);
   assign sat_y = (rsp_ff.moved_y == SAT_MAX) || (rsp_ff.moved_y == SAT_MIN);
   assign sat_z = (rsp_ff.moved_z == SAT_MAX) || (rsp_ff.moved_z == SAT_MIN);

   `RPT_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld1_ff,
      "accepted beat did not enter stage 1")
   `RPT_ASSERT_NEXT(a_last_stage_holds, clock, reset, vld4_ff && !rdy5, vld4_ff,
      "stage 4 beat lost while output blocked")
   `RPT_ASSERT_NOW(a_full_blocks, clock, reset,
      rsp_vld_ff && !rsp_ready && vld1_ff && vld2_ff && vld3_ff && vld4_ff, !req_ready,
      "full pipeline accepted a beat")
   `RPT_ASSERT_NOW(a_clip_on_rail, clock, reset, rsp_vld_ff && rsp_ff.clipped,
      sat_x || sat_y || sat_z, "clipped beat without a saturated coordinate")

endmodule

`default_nettype wire
